// ----- rtl/dgsp_pkg.sv -----
package dgsp_pkg;

  localparam int unsigned DIST_BITS = 22;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef logic [DIST_BITS-1:0] dist_t;

endpackage

// ----- rtl/dgsp_ram.sv -----
module dgsp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/dense_graph_shortest_paths.sv -----
// channel  dir  tdata fields (low bit first)                              tuser / tlast
// in_      in   row_vertex[6] col_vertex[6] edge_weight[16] src[6] pad[6]  tuser=command
// out_     out  vertex_index[6] path_distance[22] unreachable[1] pad[3]   tlast=last
// cfg_     in   vertex_count[7], write on cfg_wr_en
// a matrix write stores one edge weight; a search first initialises every vertex,
// then per round picks the closest unsettled vertex, settles it and relaxes its row
// if it is reached, and at the end delivers one result transfer per vertex
// after reset the matrix memory is cleared, one entry a cycle, all of its entries;
// in_tready is low during clearing, search and result delivery; out_tready stalls
module dense_graph_shortest_paths #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row_vertex, col_vertex, edge_weight, source_vertex
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // vertex_index, path_distance, unreachable, zero pad
  output logic        out_tlast,  // last
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  localparam int unsigned VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CB = VB + 1;
  localparam int unsigned AB = 2 * VB;
  localparam int unsigned DB = dgsp_pkg::DIST_BITS;
  localparam int unsigned VW = DB + 2;
  localparam int unsigned SB = ((WEIGHT_BITS > DB) ? WEIGHT_BITS : DB) + 1;
  localparam int unsigned MAXN = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INIT, S_PICK, S_PICKW, S_SETTLE, S_RELAX, S_RELAXW,
    S_OUT, S_OUTW
  } state_t;

  state_t state_r;
  logic [6:0] vcount_r;
  logic [CB-1:0] n_r, k_r, round_r;
  logic [VB-1:0] m_r;
  logic [AB:0] clr_r;
  logic have_r, best_reach_r, m_reach_r;
  dgsp_pkg::dist_t best_d_r, m_dist_r;
  logic [VB-1:0] best_r;
  logic [VB-1:0] src_r;
  logic src_ok_r;

  // matrix memory
  logic m_we;
  logic [AB-1:0] m_waddr, m_raddr;
  logic [WEIGHT_BITS-1:0] m_wdata, m_rdata;

  // vertex memory: {settled, reach, dist}
  logic v_we;
  logic [VB-1:0] v_waddr, v_raddr;
  logic [VW-1:0] v_wdata, v_rdata;

  dgsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(1 << AB)) u_mat (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  dgsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  logic [5:0] in_row, in_col, in_src;
  logic [15:0] in_w;
  assign in_row = in_tdata[5:0];
  assign in_col = in_tdata[11:6];
  assign in_w   = in_tdata[27:12];
  assign in_src = in_tdata[33:28];

  logic [CB-1:0] n_use;
  always_comb begin
    if (vcount_r == 7'd0) begin
      n_use = CB'(1);
    end else if (32'(vcount_r) > MAX_VERTICES) begin
      n_use = CB'(MAX_VERTICES);
    end else begin
      n_use = CB'(vcount_r);
    end
  end

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  logic wr_ok;
  assign wr_ok = (32'(in_row) < MAX_VERTICES) && (32'(in_col) < MAX_VERTICES);

  logic v_settled, v_reach;
  dgsp_pkg::dist_t v_dist;
  assign v_settled = v_rdata[VW-1];
  assign v_reach = v_rdata[VW-2];
  assign v_dist = v_rdata[DB-1:0];

  logic [SB-1:0] cand_w;
  logic [DB-1:0] cand;
  assign cand_w = SB'(m_dist_r) + SB'(m_rdata);
  assign cand = (cand_w > SB'(dgsp_pkg::DIST_MAX)) ? dgsp_pkg::DIST_MAX : cand_w[DB-1:0];

  logic k_last;
  assign k_last = (k_r == n_r - CB'(1));

  always_comb begin
    m_we = 1'b0;
    m_waddr = {VB'(in_row), VB'(in_col)};
    m_wdata = WEIGHT_BITS'(in_w);
    m_raddr = {m_r, k_r[VB-1:0]};
    v_we = 1'b0;
    v_waddr = k_r[VB-1:0];
    v_wdata = {1'b0, 1'b0, {DB{1'b0}}};
    v_raddr = k_r[VB-1:0];
    unique case (state_r)
      S_CLEAR: begin
        m_we = 1'b1;
        m_waddr = clr_r[AB-1:0];
        m_wdata = '0;
      end
      S_IDLE: begin
        m_we = in_fire && (in_tuser == dgsp_pkg::CMD_WRITE) && wr_ok;
      end
      S_INIT: begin
        v_we = 1'b1;
        v_wdata = {1'b0, src_ok_r && (k_r[VB-1:0] == src_r), {DB{1'b0}}};
      end
      S_SETTLE: begin
        v_we = 1'b1;
        v_waddr = m_r;
        v_wdata = {1'b1, m_reach_r, m_dist_r};
      end
      S_RELAXW: begin
        v_waddr = k_r[VB-1:0];
        v_we = !v_settled && (m_rdata != '0) && (!v_reach || cand < v_dist);
        v_wdata = {1'b0, 1'b1, cand};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      vcount_r <= 7'(MAXN);
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + (AB+1)'(1);
          if (clr_r == (AB+1)'((1 << AB) - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire && in_tuser == dgsp_pkg::CMD_SEARCH) begin
            n_r <= n_use;
            src_r <= VB'(in_src);
            src_ok_r <= (CB'(in_src) < n_use) && (32'(in_src) < MAX_VERTICES);
            k_r <= '0;
            round_r <= '0;
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          k_r <= k_r + CB'(1);
          if (k_last) begin
            k_r <= '0;
            have_r <= 1'b0;
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          state_r <= S_PICKW;
        end
        S_PICKW: begin
          if (!v_settled) begin
            if (!have_r) begin
              have_r <= 1'b1;
              best_r <= k_r[VB-1:0];
              best_reach_r <= v_reach;
              best_d_r <= v_dist;
            end else if (v_reach) begin
              if (!best_reach_r || v_dist <= best_d_r) begin
                best_r <= k_r[VB-1:0];
                best_reach_r <= 1'b1;
                best_d_r <= v_dist;
              end
            end else if (!best_reach_r) begin
              best_r <= k_r[VB-1:0];
            end
          end
          k_r <= k_r + CB'(1);
          state_r <= k_last ? S_SETTLE : S_PICK;
          if (k_last) begin
            m_r <= (!v_settled && (!have_r || (v_reach && (!best_reach_r ||
                    v_dist <= best_d_r)) || (!v_reach && !best_reach_r)))
                   ? k_r[VB-1:0] : best_r;
            m_reach_r <= (!v_settled && (!have_r || v_reach)) ? v_reach
                         : best_reach_r;
            m_dist_r <= (!v_settled && (!have_r || (v_reach && (!best_reach_r ||
                         v_dist <= best_d_r)))) ? v_dist : best_d_r;
          end
        end
        S_SETTLE: begin
          k_r <= '0;
          state_r <= m_reach_r ? S_RELAX : S_RELAXW;
          if (!m_reach_r) begin
            round_r <= round_r + CB'(1);
            have_r <= 1'b0;
            state_r <= (round_r == n_r - CB'(1)) ? S_OUT : S_PICK;
          end
        end
        S_RELAX: begin
          state_r <= S_RELAXW;
        end
        S_RELAXW: begin
          k_r <= k_r + CB'(1);
          state_r <= S_RELAX;
          if (k_last) begin
            k_r <= '0;
            have_r <= 1'b0;
            round_r <= round_r + CB'(1);
            state_r <= (round_r == n_r - CB'(1)) ? S_OUT : S_PICK;
          end
        end
        S_OUT: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid <= 1'b0;
            state_r <= S_OUTW;
          end
        end
        S_OUTW: begin
          out_tvalid <= 1'b1;
          out_tdata <= {3'b000, !v_reach, v_reach ? v_dist : {DB{1'b0}},
                        6'(k_r)};
          out_tlast <= k_last;
          k_r <= k_r + CB'(1);
          state_r <= k_last ? S_IDLE : S_OUT;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (state_r != S_OUTW && state_r != S_OUT && out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

endmodule
